// ===== src/srsdl_pkg.sv =====
`default_nettype none
package srsdl_pkg;

    localparam int ENTRIES    = 16;
    localparam int NAME_BYTES = 32;
    localparam int SLOT_W     = $clog2(ENTRIES);
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int POS_W      = $clog2(NAME_BYTES);
    localparam int LEN_W      = $clog2(NAME_BYTES + 1);

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [2:0] OUT_MERGED    = 3'd0;
    localparam logic [2:0] OUT_INSERTED  = 3'd1;
    localparam logic [2:0] OUT_EVICTED   = 3'd2;
    localparam logic [2:0] OUT_BAD_NAME  = 3'd3;
    localparam logic [2:0] OUT_FULL      = 3'd4;
    localparam logic [2:0] OUT_READ      = 3'd5;
    localparam logic [2:0] OUT_READ_PAST = 3'd6;

    // One list entry as held by a cell
    typedef struct packed {
        logic [NAME_BYTES-1:0][7:0] name;
        logic [LEN_W-1:0]           len;
        logic signed [7:0]          str;
        logic                       sec;
    } entry_t;

    // Per-cell update command
    typedef struct packed {
        logic load_new;
        logic shift;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIND,
        ST_DECIDE,
        ST_READ
    } state_t;

endpackage
`default_nettype wire

// ===== src/scan_result_sorted_dedup_list_core.sv =====
`default_nettype none
// Sorted list of up to 16 network names, strongest first, one cell per entry.
// A name byte that does not end a record, a clear, and an unused opcode are
// taken in the idle state alone. A read passes through a read state; a last
// name byte passes through accept, a compare state in which every cell matches
// its name against the record, and a decide state in which the cells shift,
// the new entry lands and the result word is loaded. A result waiting on
// out_ready stalls only the next item that needs the result register.
module scan_result_sorted_dedup_list_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        opcode,
    input  wire logic [7:0]        name_byte,
    input  wire logic              last_byte,
    input  wire logic signed [7:0] strength,
    input  wire logic              open_network,
    input  wire logic [3:0]        read_slot,
    input  wire logic [4:0]        read_position,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [2:0]             outcome,
    output logic [3:0]             slot,
    output logic [4:0]             entry_total,
    output logic                   dropped,
    output logic [7:0]             out_byte,
    output logic signed [7:0]      out_strength,
    output logic                   out_secure,
    output logic [5:0]             out_length
);
    import srsdl_pkg::*;

    state_t state_reg, state_next;

    logic [NAME_BYTES-1:0][7:0] rec_reg;
    logic [LEN_W-1:0]           rec_len_reg;
    logic signed [7:0]          str_reg;
    logic                       sec_reg;
    logic [SLOT_W-1:0]          rslot_reg;
    logic [POS_W-1:0]           rpos_reg;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       dropped_reg, dropped_next;
    logic [ENTRIES-1:0]         match_reg, lt_reg;

    logic       out_valid_reg, out_valid_next;
    logic [2:0] outcome_reg, outcome_next;
    logic [3:0] slot_reg, slot_next;
    logic [7:0] byte_reg, byte_next;
    logic signed [7:0] ostr_reg, ostr_next;
    logic       osec_reg, osec_next;
    logic [5:0] olen_reg, olen_next;
    logic [CNT_W-1:0] ototal_reg, ototal_next;
    logic       odrop_reg, odrop_next;
    logic       res_load;

    logic accept, out_free, bad, restart, utf_step, rec_write;

    entry_t             entries [ENTRIES];
    entry_t             new_entry;
    cell_ctl_t          ctl [ENTRIES];
    logic [ENTRIES-1:0] match_vec, lt_vec, valid_vec, load_vec;
    logic [7:0]         rd_bytes [ENTRIES];

    logic              merged, go;
    logic [SLOT_W-1:0] m_idx, at_idx;
    logic [CNT_W-1:0]  lim;
    logic [ENTRIES-1:0] a_vec;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    // Record buffer and name checker
    assign rec_write = accept && opcode == OP_BYTE && rec_len_reg < LEN_W'(NAME_BYTES);
    assign utf_step  = rec_write;

    srsdl_utf8 u_utf8 (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (restart),
        .step    (utf_step),
        .data    (name_byte),
        .bad     (bad)
    );

    always_ff @(posedge clk)
    begin
        if (rec_write)
            rec_reg[rec_len_reg[POS_W-1:0]] <= name_byte;
        if (accept && opcode == OP_BYTE)
        begin
            str_reg <= strength;
            sec_reg <= !open_network;
        end
        if (accept && opcode == OP_READ)
        begin
            rslot_reg <= read_slot;
            rpos_reg  <= read_position;
        end
        if (state_reg == ST_FIND)
        begin
            match_reg <= match_vec & valid_vec;
            lt_reg    <= lt_vec;
        end
    end

    // Row of entry cells
    always_comb
    begin
        for (int j = 0; j < ENTRIES; j++)
            valid_vec[j] = CNT_W'(j) < count_reg;
        new_entry.len = rec_len_reg;
        new_entry.str = str_reg;
        new_entry.sec = merged ? entries[m_idx].sec : sec_reg;
        for (int i = 0; i < NAME_BYTES; i++)
            new_entry.name[i] = (LEN_W'(i) < rec_len_reg) ? rec_reg[i] : 8'd0;
    end

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        srsdl_cell u_cell (
            .clk        (clk),
            .ctl        (ctl[g]),
            .prev_entry ((g == 0) ? new_entry : entries[(g == 0) ? 0 : g - 1]),
            .new_entry  (new_entry),
            .rec_name   (rec_reg),
            .rec_len    (rec_len_reg),
            .strength   (str_reg),
            .rd_pos     (rpos_reg),
            .entry      (entries[g]),
            .match      (match_vec[g]),
            .lt         (lt_vec[g]),
            .rd_byte    (rd_bytes[g])
        );
    end

    // Locate the merged entry
    always_comb
    begin
        merged = |match_reg;
        m_idx  = '0;
        for (int j = 0; j < ENTRIES; j++)
            if (match_reg[j])
                m_idx = m_idx | SLOT_W'(j);
    end

    // Next state, cell commands and result
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        restart        = 1'b0;
        go             = 1'b0;
        res_load       = 1'b0;
        lim            = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        outcome_next   = outcome_reg;
        slot_next      = slot_reg;
        byte_next      = byte_reg;
        ostr_next      = ostr_reg;
        osec_next      = osec_reg;
        olen_next      = olen_reg;
        ototal_next    = ototal_reg;
        odrop_next     = odrop_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (opcode)
                        OP_CLEAR:
                        begin
                            count_next   = '0;
                            dropped_next = 1'b0;
                            restart      = 1'b1;
                        end
                        OP_BYTE:
                        begin
                            if (last_byte)
                                state_next = ST_FIND;
                        end
                        OP_READ:  state_next = ST_READ;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_FIND:
                state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                if (out_free)
                begin
                    state_next     = ST_IDLE;
                    restart        = 1'b1;
                    res_load       = 1'b1;
                    out_valid_next = 1'b1;
                    slot_next      = '0;
                    byte_next      = '0;
                    ostr_next      = '0;
                    osec_next      = 1'b0;
                    olen_next      = '0;
                    priority if (bad)
                    begin
                        outcome_next = OUT_BAD_NAME;
                        dropped_next = 1'b1;
                    end
                    else if (merged)
                    begin
                        outcome_next = OUT_MERGED;
                        if (str_reg > entries[m_idx].str)
                        begin
                            go        = 1'b1;
                            lim       = CNT_W'(m_idx);
                            slot_next = 4'(at_idx);
                        end
                        else
                            slot_next = 4'(m_idx);
                    end
                    else if (count_reg >= CNT_W'(ENTRIES))
                    begin
                        dropped_next = 1'b1;
                        if (str_reg > entries[ENTRIES-1].str)
                        begin
                            go           = 1'b1;
                            lim          = CNT_W'(ENTRIES - 1);
                            outcome_next = OUT_EVICTED;
                            slot_next    = 4'(at_idx);
                        end
                        else
                            outcome_next = OUT_FULL;
                    end
                    else
                    begin
                        go           = 1'b1;
                        outcome_next = OUT_INSERTED;
                        count_next   = count_reg + CNT_W'(1);
                        slot_next    = 4'(at_idx);
                    end
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    state_next     = ST_IDLE;
                    res_load       = 1'b1;
                    out_valid_next = 1'b1;
                    slot_next      = 4'(rslot_reg);
                    byte_next      = '0;
                    ostr_next      = '0;
                    osec_next      = 1'b0;
                    olen_next      = '0;
                    if (CNT_W'(rslot_reg) >= count_reg)
                        outcome_next = OUT_READ_PAST;
                    else
                    begin
                        outcome_next = OUT_READ;
                        byte_next    = rd_bytes[rslot_reg];
                        ostr_next    = entries[rslot_reg].str;
                        osec_next    = entries[rslot_reg].sec;
                        olen_next    = 6'(entries[rslot_reg].len);
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        // Capture the list totals with the result word
        if (res_load)
        begin
            ototal_next = count_next;
            odrop_next  = dropped_next;
        end
    end

    // Per-cell shift and load commands
    always_comb
    begin
        at_idx = '0;
        for (int j = 0; j < ENTRIES; j++)
            a_vec[j] = (CNT_W'(j) < lim) ? lt_reg[j] : 1'b1;
        for (int j = 0; j < ENTRIES; j++)
        begin
            load_vec[j]     = go && CNT_W'(j) <= lim && a_vec[j] &&
                              (j == 0 || !a_vec[(j == 0) ? 0 : j - 1]);
            ctl[j].load_new = load_vec[j];
            ctl[j].shift    = go && j > 0 && CNT_W'(j) <= lim &&
                              a_vec[(j == 0) ? 0 : j - 1];
            if (CNT_W'(j) <= lim && a_vec[j] && (j == 0 || !a_vec[(j == 0) ? 0 : j - 1]))
                at_idx = at_idx | SLOT_W'(j);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            rec_len_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
            if (restart)
                rec_len_reg <= '0;
            else if (rec_write)
                rec_len_reg <= rec_len_reg + LEN_W'(1);
        end
    end

    // Hold the result word
    always_ff @(posedge clk)
    begin
        outcome_reg <= outcome_next;
        slot_reg    <= slot_next;
        byte_reg    <= byte_next;
        ostr_reg    <= ostr_next;
        osec_reg    <= osec_next;
        olen_reg    <= olen_next;
        ototal_reg  <= ototal_next;
        odrop_reg   <= odrop_next;
    end

    assign out_valid    = out_valid_reg;
    assign outcome      = outcome_reg;
    assign slot         = slot_reg;
    assign entry_total  = ototal_reg;
    assign dropped      = odrop_reg;
    assign out_byte     = byte_reg;
    assign out_strength = ostr_reg;
    assign out_secure   = osec_reg;
    assign out_length   = olen_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ENTRIES))
        else $error("entry count above capacity");

    a_single_load: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(load_vec))
        else $error("more than one cell loads the record");

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DECIDE |-> $onehot0(match_reg))
        else $error("name listed twice");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        accept && opcode == OP_CLEAR |=> count_reg == '0 && !dropped_reg)
        else $error("clear did not empty the list");

endmodule
`default_nettype wire

// ===== src/srsdl_utf8.sv =====
`default_nettype none
module srsdl_utf8 (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       restart,
    input  wire logic       step,
    input  wire logic [7:0] data,
    output logic            bad
);
    import srsdl_pkg::*;

    logic [1:0]  pending_reg, pending_next;
    logic [1:0]  extra_reg, extra_next;
    logic [20:0] cp_reg, cp_next;
    logic        invalid_reg, invalid_next;

    // Advance the decoder by one byte
    always_comb
    begin
        pending_next = pending_reg;
        extra_next   = extra_reg;
        cp_next      = cp_reg;
        invalid_next = invalid_reg;
        if (restart)
        begin
            pending_next = 2'd0;
            extra_next   = 2'd0;
            cp_next      = 21'd0;
            invalid_next = 1'b0;
        end
        else if (step && !invalid_reg)
        begin
            if (pending_reg == 2'd0)
            begin
                if (data < 8'h20 || data == 8'h7f)
                    invalid_next = 1'b1;
                else if (data < 8'h80)
                    invalid_next = 1'b0;
                else if ((data & 8'he0) == 8'hc0)
                begin
                    extra_next   = 2'd1;
                    pending_next = 2'd1;
                    cp_next      = {16'd0, data[4:0]};
                end
                else if ((data & 8'hf0) == 8'he0)
                begin
                    extra_next   = 2'd2;
                    pending_next = 2'd2;
                    cp_next      = {17'd0, data[3:0]};
                end
                else if ((data & 8'hf8) == 8'hf0)
                begin
                    extra_next   = 2'd3;
                    pending_next = 2'd3;
                    cp_next      = {18'd0, data[2:0]};
                end
                else
                    invalid_next = 1'b1;
            end
            else if ((data & 8'hc0) != 8'h80)
                invalid_next = 1'b1;
            else
            begin
                cp_next      = {cp_reg[14:0], data[5:0]};
                pending_next = pending_reg - 2'd1;
                // Reject overlong forms, surrogates and out-of-range values
                if (pending_next == 2'd0)
                begin
                    if ((extra_reg == 2'd1 && cp_next < 21'h80) ||
                        (extra_reg == 2'd2 && cp_next < 21'h800) ||
                        (extra_reg == 2'd3 && cp_next < 21'h10000) ||
                        cp_next > 21'h10ffff ||
                        (cp_next >= 21'hd800 && cp_next <= 21'hdfff))
                        invalid_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
            extra_reg   <= 2'd0;
            cp_reg      <= 21'd0;
            invalid_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
            extra_reg   <= extra_next;
            cp_reg      <= cp_next;
            invalid_reg <= invalid_next;
        end
    end

    assign bad = invalid_reg || (pending_reg != 2'd0);

endmodule
`default_nettype wire

// ===== src/srsdl_cell.sv =====
`default_nettype none
module srsdl_cell (
    input  wire logic                                   clk,
    input  wire srsdl_pkg::cell_ctl_t                   ctl,
    input  wire srsdl_pkg::entry_t                      prev_entry,
    input  wire srsdl_pkg::entry_t                      new_entry,
    input  wire logic [srsdl_pkg::NAME_BYTES-1:0][7:0]  rec_name,
    input  wire logic [srsdl_pkg::LEN_W-1:0]            rec_len,
    input  wire logic signed [7:0]                      strength,
    input  wire logic [srsdl_pkg::POS_W-1:0]            rd_pos,
    output srsdl_pkg::entry_t                           entry,
    output logic                                        match,
    output logic                                        lt,
    output logic [7:0]                                  rd_byte
);
    import srsdl_pkg::*;

    entry_t entry_reg;

    // Load the new record, take the neighbor's entry, or hold
    always_ff @(posedge clk)
    begin
        if (ctl.load_new)
            entry_reg <= new_entry;
        else if (ctl.shift)
            entry_reg <= prev_entry;
    end

    // Compare the held name against the record
    always_comb
    begin
        match = (entry_reg.len == rec_len);
        for (int i = 0; i < NAME_BYTES; i++)
        begin
            if (LEN_W'(i) < rec_len && entry_reg.name[i] != rec_name[i])
                match = 1'b0;
        end
    end

    assign lt      = entry_reg.str < strength;
    assign rd_byte = (LEN_W'(rd_pos) < entry_reg.len) ? entry_reg.name[rd_pos] : 8'd0;
    assign entry   = entry_reg;

endmodule
`default_nettype wire

// ===== test/scan_result_sorted_dedup_list_core_tb.sv =====
`default_nettype none
module scan_result_sorted_dedup_list_core_tb;
    import srsdl_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;

    // One word toward the list, and one word of result
    typedef struct {
        logic [1:0]        op;
        logic [7:0]        nbyte;
        logic              last;
        logic signed [7:0] str;
        logic              open_net;
        logic [3:0]        rslot;
        logic [4:0]        rpos;
    } scan_word_t;

    typedef struct {
        logic [2:0]        outcome;
        logic [3:0]        slot;
        logic [4:0]        total;
        logic              dropped;
        logic [7:0]        obyte;
        logic signed [7:0] ostr;
        logic              osec;
        logic [5:0]        olen;
    } list_reply_t;

    typedef struct {
        scan_word_t  w;
        logic        typed;
        list_reply_t want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [1:0] opcode;
    logic [7:0] name_byte;
    logic last_byte;
    logic signed [7:0] strength;
    logic open_network;
    logic [3:0] read_slot;
    logic [4:0] read_position;
    logic out_valid;
    logic out_ready;
    logic [2:0] outcome;
    logic [3:0] slot;
    logic [4:0] entry_total;
    logic dropped;
    logic [7:0] out_byte;
    logic signed [7:0] out_strength;
    logic out_secure;
    logic [5:0] out_length;

    scan_result_sorted_dedup_list_core uut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .name_byte(name_byte), .last_byte(last_byte),
        .strength(strength), .open_network(open_network), .read_slot(read_slot),
        .read_position(read_position), .out_valid(out_valid), .out_ready(out_ready),
        .outcome(outcome), .slot(slot), .entry_total(entry_total), .dropped(dropped),
        .out_byte(out_byte), .out_strength(out_strength), .out_secure(out_secure),
        .out_length(out_length)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Shadow copy of the list and of the record being assembled
    logic [7:0]        lst_name [ENTRIES][NAME_BYTES];
    logic [5:0]        lst_len  [ENTRIES];
    logic signed [7:0] lst_str  [ENTRIES];
    logic              lst_sec  [ENTRIES];
    int                lst_count;
    logic              lst_dropped;
    logic [7:0]        rec_bytes [NAME_BYTES];
    int                rec_len;
    int                rec_pending;
    int                rec_extra;
    logic [20:0]       rec_cp;
    logic              rec_bad;

    list_reply_t expected_replies[$];
    int          error_count;
    int          idle_cycles;
    int          words_sent;
    int          out_wait;

    function automatic void restart_record();
        rec_len = 0;
        rec_pending = 0;
        rec_extra = 0;
        rec_cp = '0;
        rec_bad = 1'b0;
    endfunction

    // UTF-8 check of one byte of the record
    function automatic void check_utf8(logic [7:0] c);
        if (rec_bad)
            return;
        if (rec_pending == 0)
        begin
            if (c < 8'h20 || c == 8'h7f)
                rec_bad = 1'b1;
            else if (c < 8'h80)
                return;
            else if ((c & 8'he0) == 8'hc0)
            begin
                rec_extra = 1;
                rec_cp = 21'(c & 8'h1f);
            end
            else if ((c & 8'hf0) == 8'he0)
            begin
                rec_extra = 2;
                rec_cp = 21'(c & 8'h0f);
            end
            else if ((c & 8'hf8) == 8'hf0)
            begin
                rec_extra = 3;
                rec_cp = 21'(c & 8'h07);
            end
            else
                rec_bad = 1'b1;
            if (!rec_bad && c >= 8'h80)
                rec_pending = rec_extra;
            return;
        end
        if ((c & 8'hc0) != 8'h80)
        begin
            rec_bad = 1'b1;
            return;
        end
        rec_cp = {rec_cp[14:0], c[5:0]};
        rec_pending--;
        if (rec_pending != 0)
            return;
        if ((rec_extra == 1 && rec_cp < 21'h80) || (rec_extra == 2 && rec_cp < 21'h800)
            || (rec_extra == 3 && rec_cp < 21'h10000) || rec_cp > 21'h10ffff
            || (rec_cp >= 21'hd800 && rec_cp <= 21'hdfff))
            rec_bad = 1'b1;
    endfunction

    function automatic void copy_entry(int to, int from);
        lst_name[to] = lst_name[from];
        lst_len[to]  = lst_len[from];
        lst_str[to]  = lst_str[from];
        lst_sec[to]  = lst_sec[from];
    endfunction

    function automatic bit name_matches(int e);
        if (lst_len[e] != rec_len)
            return 0;
        for (int k = 0; k < rec_len; k++)
            if (lst_name[e][k] != rec_bytes[k])
                return 0;
        return 1;
    endfunction

    // Close the record: merge, insert, evict or drop
    function automatic void close_record(logic signed [7:0] s, logic sec,
                                         ref list_reply_t r);
        int at;
        int i;
        logic [7:0] keep_name [NAME_BYTES];
        logic [5:0] keep_len;
        logic keep_sec;
        r.slot = '0;
        r.outcome = OUT_INSERTED;
        if (rec_bad || rec_pending != 0)
        begin
            lst_dropped = 1'b1;
            r.outcome = OUT_BAD_NAME;
            return;
        end
        for (i = 0; i < lst_count; i++)
        begin
            if (name_matches(i))
            begin
                if (s > lst_str[i])
                begin
                    keep_name = lst_name[i];
                    keep_len = lst_len[i];
                    keep_sec = lst_sec[i];
                    at = i;
                    while (at > 0 && lst_str[at-1] < s)
                    begin
                        copy_entry(at, at - 1);
                        at--;
                    end
                    lst_name[at] = keep_name;
                    lst_len[at] = keep_len;
                    lst_sec[at] = keep_sec;
                    lst_str[at] = s;
                    i = at;
                end
                r.slot = 4'(i);
                r.outcome = OUT_MERGED;
                return;
            end
        end
        if (lst_count >= ENTRIES)
        begin
            lst_dropped = 1'b1;
            if (s <= lst_str[ENTRIES-1])
            begin
                r.outcome = OUT_FULL;
                return;
            end
            lst_count = ENTRIES - 1;
            r.outcome = OUT_EVICTED;
        end
        at = lst_count;
        while (at > 0 && lst_str[at-1] < s)
        begin
            copy_entry(at, at - 1);
            at--;
        end
        for (int k = 0; k < NAME_BYTES; k++)
            lst_name[at][k] = (k < rec_len) ? rec_bytes[k] : 8'h00;
        lst_len[at] = 6'(rec_len);
        lst_str[at] = s;
        lst_sec[at] = sec;
        lst_count++;
        r.slot = 4'(at);
    endfunction

    // Advance the shadow list by one accepted word; queue any result
    function automatic void predict_list(scan_word_t w);
        list_reply_t r;
        r = '{default: '0};
        case (w.op)
            OP_CLEAR:
            begin
                lst_count = 0;
                lst_dropped = 1'b0;
                restart_record();
                return;
            end
            OP_BYTE:
            begin
                if (rec_len < NAME_BYTES)
                begin
                    rec_bytes[rec_len] = w.nbyte;
                    rec_len++;
                    check_utf8(w.nbyte);
                end
                if (!w.last)
                    return;
                close_record(w.str, !w.open_net, r);
                restart_record();
            end
            OP_READ:
            begin
                r.slot = w.rslot;
                if (w.rslot >= lst_count)
                    r.outcome = OUT_READ_PAST;
                else
                begin
                    r.outcome = OUT_READ;
                    r.olen = lst_len[w.rslot];
                    r.ostr = lst_str[w.rslot];
                    r.osec = lst_sec[w.rslot];
                    if (w.rpos < r.olen)
                        r.obyte = lst_name[w.rslot][w.rpos];
                end
            end
            default:
                return;
        endcase
        r.total = 5'(lst_count);
        r.dropped = lst_dropped;
        expected_replies.push_back(r);
    endfunction

    // Send one word, holding it until accepted
    task automatic send_word(scan_word_t w);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        opcode        <= w.op;
        name_byte     <= w.nbyte;
        last_byte     <= w.last;
        strength      <= w.str;
        open_network  <= w.open_net;
        read_slot     <= w.rslot;
        read_position <= w.rpos;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_list(w);
        words_sent++;
    endtask

    function automatic scan_word_t mk(int op, int b, int last, int s, int o,
                                      int rs, int rp);
        scan_word_t w;
        w.op = 2'(op); w.nbyte = 8'(b); w.last = 1'(last); w.str = 8'(s);
        w.open_net = 1'(o); w.rslot = 4'(rs); w.rpos = 5'(rp);
        return w;
    endfunction

    task automatic send_name(string nm, logic signed [7:0] s, logic o);
        for (int k = 0; k < nm.len(); k++)
            send_word(mk(OP_BYTE, nm[k], k == nm.len() - 1, s, o, $urandom, $urandom));
    endtask

    // Random name: mostly valid UTF-8 from a small pool so merges happen
    task automatic send_random_name();
        logic [7:0] b [$];
        int n;
        int kind;
        logic [20:0] cp;
        b.delete();
        kind = $urandom_range(0, 9);
        if (kind < 5)
        begin
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++)
                b.push_back(8'(8'h41 + $urandom_range(0, 2)));
        end
        else if (kind < 8)
        begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 6);
            while (b.size() < n)
            begin
                case ($urandom_range(0, 3))
                    0: b.push_back(8'($urandom_range(8'h20, 8'h7e)));
                    1:
                    begin
                        cp = 21'($urandom_range(21'h80, 21'h7ff));
                        b.push_back(8'hc0 | cp[10:6]);
                        b.push_back(8'h80 | cp[5:0]);
                    end
                    2:
                    begin
                        cp = 21'($urandom_range(21'h800, 21'hffff));
                        b.push_back(8'he0 | cp[15:12]);
                        b.push_back(8'h80 | cp[11:6]);
                        b.push_back(8'h80 | cp[5:0]);
                    end
                    default:
                    begin
                        cp = 21'($urandom_range(21'h10000, 21'h10ffff));
                        b.push_back(8'hf0 | cp[20:18]);
                        b.push_back(8'h80 | cp[17:12]);
                        b.push_back(8'h80 | cp[11:6]);
                        b.push_back(8'h80 | cp[5:0]);
                    end
                endcase
            end
        end
        else
        begin
            n = $urandom_range(1, 5);
            for (int k = 0; k < n; k++)
                b.push_back(8'($urandom));
        end
        for (int k = 0; k < b.size(); k++)
            send_word(mk(OP_BYTE, b[k], k == b.size() - 1, $urandom, $urandom,
                         $urandom, $urandom));
    endtask

    task automatic send_read();
        int hi;
        hi = (lst_count > 0) ? lst_count - 1 : 0;
        if ($urandom_range(0, 4) == 0)
            send_word(mk(OP_READ, $urandom, $urandom, $urandom, $urandom,
                         $urandom_range(0, 15), $urandom));
        else
            send_word(mk(OP_READ, $urandom, $urandom, $urandom, $urandom,
                         $urandom_range(0, hi), $urandom));
    endtask

    // Compare each result word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_replies.size() == 0)
            begin
                $error("unexpected result word: outcome %0d", outcome);
                error_count++;
            end
            else
            begin
                list_reply_t e;
                e = expected_replies.pop_front();
                if (outcome !== e.outcome)
                begin
                    $error("outcome: expected %0d, got %0d", e.outcome, outcome);
                    error_count++;
                end
                if (slot !== e.slot)
                begin
                    $error("slot: expected %0d, got %0d", e.slot, slot);
                    error_count++;
                end
                if (entry_total !== e.total)
                begin
                    $error("entry_total: expected %0d, got %0d", e.total, entry_total);
                    error_count++;
                end
                if (dropped !== e.dropped)
                begin
                    $error("dropped: expected %0d, got %0d", e.dropped, dropped);
                    error_count++;
                end
                if (out_byte !== e.obyte)
                begin
                    $error("out_byte: expected %0h, got %0h", e.obyte, out_byte);
                    error_count++;
                end
                if (out_strength !== e.ostr)
                begin
                    $error("out_strength: expected %0d, got %0d", e.ostr, out_strength);
                    error_count++;
                end
                if (out_secure !== e.osec)
                begin
                    $error("out_secure: expected %0d, got %0d", e.osec, out_secure);
                    error_count++;
                end
                if (out_length !== e.olen)
                begin
                    $error("out_length: expected %0d, got %0d", e.olen, out_length);
                    error_count++;
                end
            end
        end
    end

    // Hold off each result word for a random number of cycles
    always @(posedge clk)
    begin
        int draw;
        draw = $urandom_range(0, 18);
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_wait  <= draw;
        end
        else if (out_valid && out_ready)
        begin
            out_wait  <= draw;
            out_ready <= (draw == 0);
        end
        else if (out_valid && out_wait > 0)
        begin
            out_wait  <= out_wait - 1;
            out_ready <= (out_wait == 1);
        end
        else if (out_wait == 0)
            out_ready <= 1'b1;
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("scan_result_sorted_dedup_list_core_tb: done, errors");
            $finish;
        end
    end

    stim_row_t directed[$];

    task automatic add_row(scan_word_t w, logic typed, list_reply_t r);
        stim_row_t row;
        row.w = w;
        row.typed = typed;
        row.want = r;
        directed.push_back(row);
    endtask

    initial
    begin
        list_reply_t none;
        none = '{default: '0};
        error_count = 0;
        idle_cycles = 0;
        words_sent = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_CLEAR;
        name_byte = '0;
        last_byte = 1'b0;
        strength = '0;
        open_network = 1'b0;
        read_slot = '0;
        read_position = '0;
        for (int i = 0; i < ENTRIES; i++)
            for (int k = 0; k < NAME_BYTES; k++)
                lst_name[i][k] = 8'h00;
        lst_count = 0;
        lst_dropped = 1'b0;
        restart_record();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: read on empty list, extremes, bad names, unused opcode
        add_row(mk(OP_READ, 8'h00, 1'b0, 8'sd0, 1'b0, 4'd15, 5'd31), 1'b1,
                '{OUT_READ_PAST, 4'd15, 5'd0, 1'b0, 8'h00, 8'sd0, 1'b0, 6'd0});
        add_row(mk(OP_BYTE, 8'h00, 1'b1, 8'sd0, 1'b0, 4'd0, 5'd0), 1'b1,
                '{OUT_BAD_NAME, 4'd0, 5'd0, 1'b1, 8'h00, 8'sd0, 1'b0, 6'd0});
        add_row(mk(2'd3, 8'hff, 1'b1, -8'sd128, 1'b1, 4'd15, 5'd31), 1'b0, none);
        add_row(mk(OP_CLEAR, 8'hff, 1'b1, 8'sd127, 1'b1, 4'd15, 5'd31), 1'b0, none);
        add_row(mk(OP_BYTE, 8'h7e, 1'b1, 8'sd127, 1'b0, 4'd0, 5'd0), 1'b1,
                '{OUT_INSERTED, 4'd0, 5'd1, 1'b0, 8'h00, 8'sd0, 1'b0, 6'd0});
        add_row(mk(OP_BYTE, 8'h7f, 1'b1, 8'sd0, 1'b0, 4'd0, 5'd0), 1'b1,
                '{OUT_BAD_NAME, 4'd0, 5'd1, 1'b1, 8'h00, 8'sd0, 1'b0, 6'd0});
        add_row(mk(OP_BYTE, 8'hc1, 1'b0, 8'sd0, 1'b0, 4'd0, 5'd0), 1'b0, none);
        add_row(mk(OP_READ, 8'h00, 1'b0, 8'sd0, 1'b0, 4'd0, 5'd0), 1'b0, none);
        add_row(mk(OP_BYTE, 8'hbf, 1'b1, -8'sd128, 1'b1, 4'd0, 5'd0), 1'b0, none);
        add_row(mk(OP_BYTE, 8'he2, 1'b1, -8'sd128, 1'b1, 4'd0, 5'd0), 1'b0, none);
        add_row(mk(OP_BYTE, 8'hed, 1'b0, 8'sd0, 1'b0, 4'd0, 5'd0), 1'b0, none);
        add_row(mk(OP_BYTE, 8'ha0, 1'b0, 8'sd0, 1'b0, 4'd0, 5'd0), 1'b0, none);
        add_row(mk(OP_BYTE, 8'h80, 1'b1, 8'sd5, 1'b0, 4'd0, 5'd0), 1'b0, none);
        add_row(mk(OP_BYTE, 8'hf4, 1'b0, 8'sd0, 1'b0, 4'd0, 5'd0), 1'b0, none);
        add_row(mk(OP_BYTE, 8'h90, 1'b0, 8'sd0, 1'b0, 4'd0, 5'd0), 1'b0, none);
        add_row(mk(OP_BYTE, 8'h80, 1'b0, 8'sd0, 1'b0, 4'd0, 5'd0), 1'b0, none);
        add_row(mk(OP_BYTE, 8'h80, 1'b1, 8'sd5, 1'b0, 4'd0, 5'd0), 1'b0, none);
        add_row(mk(OP_BYTE, 8'h7e, 1'b1, -8'sd128, 1'b1, 4'd0, 5'd0), 1'b0, none);
        add_row(mk(OP_READ, 8'h00, 1'b0, 8'sd0, 1'b0, 4'd0, 5'd31), 1'b0, none);
        add_row(mk(OP_READ, 8'h00, 1'b0, 8'sd0, 1'b0, 4'd0, 5'd0), 1'b0, none);

        foreach (directed[i])
        begin
            send_word(directed[i].w);
            if (directed[i].typed && expected_replies.size() > 0)
                expected_replies[$] = directed[i].want;
        end

        // Fill past capacity with one long name, then many distinct names
        for (int k = 0; k < 40; k++)
            send_word(mk(OP_BYTE, 8'h78, k == 39, 8'sd0, 1'b0, 4'd0, 5'd0));
        for (int i = 0; i < 20; i++)
            send_name($sformatf("n%0d", i), $urandom, $urandom);
        for (int i = 0; i < ENTRIES; i++)
            send_word(mk(OP_READ, 8'h00, 1'b0, 8'sd0, 1'b0, i, $urandom));

        // Random part: names with random content, reads, clears, noise
        while (words_sent < 1400)
        begin
            case ($urandom_range(0, 19))
                0:
                    send_word(mk(OP_CLEAR, $urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom));
                1:
                    send_word(mk(2'd3, $urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom));
                2, 3, 4, 5, 6:
                    send_read();
                default:
                    send_random_name();
            endcase
        end
        in_valid <= 1'b0;

        while (expected_replies.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("scan_result_sorted_dedup_list_core_tb: done, clean");
        else
            $display("scan_result_sorted_dedup_list_core_tb: done, errors");
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
src/srsdl_pkg.sv
src/srsdl_utf8.sv
src/srsdl_cell.sv
src/scan_result_sorted_dedup_list_core.sv
test/scan_result_sorted_dedup_list_core_tb.sv
